// ----- rtl/mtt_pkg.sv -----
// Shared types, constants and the clamp helper function of the mouse cursor tracker.
`timescale 1ns / 1ps
package mtt_pkg;

  localparam int ButtonsDefault = 3;
  localparam int DivBits        = 16;
  localparam int RatioBits      = 15;
  localparam int CntBits        = $clog2(DivBits + 1);

  localparam logic [2:0] ACT_PACKET  = 3'd0;
  localparam logic [2:0] ACT_PRESS   = 3'd1;
  localparam logic [2:0] ACT_RELEASE = 3'd2;
  localparam logic [2:0] ACT_MOTION  = 3'd3;
  localparam logic [2:0] ACT_SETPOS  = 3'd4;

  localparam logic [2:0] REG_XLO   = 3'd0;
  localparam logic [2:0] REG_XHI   = 3'd1;
  localparam logic [2:0] REG_YLO   = 3'd2;
  localparam logic [2:0] REG_YHI   = 3'd3;
  localparam logic [2:0] REG_RATH  = 3'd4;
  localparam logic [2:0] REG_RATV  = 3'd5;
  localparam logic [2:0] REG_EMASK = 3'd6;
  localparam logic [2:0] REG_NOTEN = 3'd7;

  localparam logic signed [15:0] RESET_XHI  = 16'sd639;
  localparam logic signed [15:0] RESET_YHI  = 16'sd199;
  localparam logic signed [15:0] RESET_POSX = 16'sd320;
  localparam logic signed [15:0] RESET_POSY = 16'sd100;
  localparam logic [RatioBits-1:0] RESET_RATH = 15'd8;
  localparam logic [RatioBits-1:0] RESET_RATV = 15'd16;

  typedef struct packed {
    logic                 done;
    logic [DivBits-1:0]   quotient;
    logic [RatioBits-1:0] remainder;
  } div_res_t;

  // Clamps a wide signed value to the range spanned by two bounds in either order.
  function automatic logic signed [15:0] clamp(input logic signed [17:0] v,
                                               input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (v < 18'(lo)) clamp = lo;
    else if (v > 18'(hi)) clamp = hi;
    else clamp = v[15:0];
  endfunction

endpackage

// ----- rtl/mtt_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module mtt_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic [mtt_pkg::DivBits-1:0]       dividend,
  input  logic [mtt_pkg::RatioBits-1:0]     divisor,
  output mtt_pkg::div_res_t                 res
);
  import mtt_pkg::*;

  logic [CntBits-1:0]   count;
  logic                 running;
  logic [RatioBits-1:0] rem;
  logic [DivBits-1:0]   quo;
  logic [RatioBits-1:0] dvs;
  logic                 done;
  logic [RatioBits:0]   shifted;
  logic                 fits;
  logic [RatioBits:0]   diff;

  assign shifted = {rem, quo[DivBits-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        count   <= '0;
        rem     <= '0;
        quo     <= dividend;
        dvs     <= divisor;
      end else if (running) begin
        rem   <= fits ? diff[RatioBits-1:0] : shifted[RatioBits-1:0];
        quo   <= {quo[DivBits-2:0], fits};
        count <= count + 1'b1;
        if (count == CntBits'(DivBits - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

// ----- rtl/ps2_mouse_cursor_tracker.sv -----
// Top level of the mouse cursor tracker: action sequencer, state and latches.
`timescale 1ns / 1ps
// Usage: an action is taken on a rising edge with start high and busy low.
// Its single result appears on the output ports for one cycle with done high;
// the receiver must take it then, as it cannot hold results back.
// Queries, motion reads and set position finish without leaving idle: done follows
// the transfer on the next edge and busy never rises.
// A packet with no motion passes through S_FIN alone, with busy high while there.
// A packet with motion runs two divisions on the shared bit-serial divider,
// X then Y. S_DIVX and S_DIVY each take their quotient when the divider is
// done, the Y division starting as the X quotient is taken, and S_FIN then
// latches the buttons; busy is high from the transfer until the result.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, which the block itself does not enforce; a
// range write clamps the cursor at once, and a ratio of zero is ignored.
// Reset (rst, synchronous) restores the tracking registers and state to their defaults:
// cursor at 320,100, range 0..639 by 0..199, ratios 8 and 16, all counters clear.
module ps2_mouse_cursor_tracker #(
  parameter int BUTTONS = mtt_pkg::ButtonsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [2:0]         action,
  input  logic [7:0]         packet_status,
  input  logic [7:0]         motion_dx,
  input  logic [7:0]         motion_dy,
  input  logic [1:0]         button_select,
  input  logic signed [15:0] new_x,
  input  logic signed [15:0] new_y,
  output logic [2:0]         buttons_now,
  output logic signed [15:0] position_x,
  output logic signed [15:0] position_y,
  output logic [6:0]         event_bits,
  output logic               notify,
  output logic [15:0]        info_count,
  output logic signed [15:0] info_x,
  output logic signed [15:0] info_y,
  output logic signed [15:0] mickeys_x,
  output logic signed [15:0] mickeys_y
);
  import mtt_pkg::*;

  localparam int SelBits = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIVX = 2'd1;
  localparam logic [1:0] S_DIVY = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;

  logic signed [15:0] range_x_low, range_x_high, range_y_low, range_y_high;
  logic [RatioBits-1:0] ratio_horizontal, ratio_vertical;
  logic [6:0] event_mask;
  logic       notify_enable;

  logic signed [15:0] pos_x, pos_y, mickey_x, mickey_y, fraction_x, fraction_y;
  logic [BUTTONS-1:0] last_buttons;
  logic [BUTTONS-1:0] nb_hold;
  logic [15:0]        press_count   [BUTTONS];
  logic signed [15:0] press_pos_x   [BUTTONS];
  logic signed [15:0] press_pos_y   [BUTTONS];
  logic [15:0]        release_count [BUTTONS];
  logic signed [15:0] release_pos_x [BUTTONS];
  logic signed [15:0] release_pos_y [BUTTONS];

  logic               neg_x, neg_y;
  logic [DivBits-1:0] mag_y;

  // Range as it stands after a write in this cycle.
  logic signed [15:0] xlo_next, xhi_next, ylo_next, yhi_next;

  logic accept;
  logic signed [8:0]  dx;
  logic signed [9:0]  dy;
  logic               moving;
  logic [BUTTONS-1:0] nb;
  logic signed [16:0] sum_x, sum_y;
  logic [16:0]        abs_x, abs_y;
  logic [1:0]         sel2;
  logic [SelBits-1:0] sel;

  logic               div_go;
  logic [DivBits-1:0] div_dividend;
  logic [RatioBits-1:0] div_divisor;
  div_res_t           dres;
  logic               div_neg;
  logic signed [16:0] step;
  logic signed [17:0] moved;
  logic signed [15:0] frac_new;
  logic signed [15:0] axis_pos;
  logic signed [15:0] axis_lo, axis_hi;
  logic signed [15:0] axis_new;

  logic [BUTTONS-1:0] diff;
  logic [6:0]         ev;

  assign accept = start && !busy;
  assign busy   = state != S_IDLE;

  always_comb begin
    xlo_next = range_x_low;
    xhi_next = range_x_high;
    ylo_next = range_y_low;
    yhi_next = range_y_high;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_XLO: xlo_next = cfg_data;
        REG_XHI: xhi_next = cfg_data;
        REG_YLO: ylo_next = cfg_data;
        REG_YHI: yhi_next = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    dx     = {packet_status[4], motion_dx};
    dy     = -10'(signed'({packet_status[5], motion_dy}));
    moving = (dx != 9'sd0) || (dy != 10'sd0);
    nb     = packet_status[BUTTONS-1:0];
    sum_x  = 17'(fraction_x) + (17'(dx) <<< 3);
    sum_y  = 17'(fraction_y) + (17'(dy) <<< 3);
    abs_x  = sum_x[16] ? 17'(-sum_x) : 17'(sum_x);
    abs_y  = sum_y[16] ? 17'(-sum_y) : 17'(sum_y);
    sel2   = (button_select == 2'd3) ? 2'd2 : button_select;
    if (32'(sel2) >= BUTTONS) sel = SelBits'(BUTTONS - 1);
    else sel = SelBits'(sel2);
  end

  assign div_go       = (accept && action == ACT_PACKET && moving) ||
                        (state == S_DIVX && dres.done);
  assign div_dividend = (state == S_IDLE) ? abs_x[DivBits-1:0] : mag_y;
  assign div_divisor  = (state == S_IDLE) ? ratio_horizontal : ratio_vertical;

  mtt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (dres)
  );

  // Quotient and remainder take the sign of the dividend (truncation toward zero).
  always_comb begin
    div_neg  = (state == S_DIVX) ? neg_x : neg_y;
    axis_pos = (state == S_DIVX) ? pos_x : pos_y;
    axis_lo  = (state == S_DIVX) ? range_x_low : range_y_low;
    axis_hi  = (state == S_DIVX) ? range_x_high : range_y_high;
    step     = div_neg ? -17'(signed'({1'b0, dres.quotient}))
                       : 17'(signed'({1'b0, dres.quotient}));
    frac_new = div_neg ? -16'(signed'({1'b0, dres.remainder}))
                       : 16'(signed'({1'b0, dres.remainder}));
    moved    = 18'(axis_pos) + 18'(step);
    axis_new = clamp(moved, axis_lo, axis_hi);
  end

  always_comb begin
    diff = nb_hold ^ last_buttons;
    ev   = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      if (diff[i]) begin
        if (nb_hold[i]) ev[2*i+1] = 1'b1;
        else ev[2*i+2] = 1'b1;
      end
    end
  end

  logic moved_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      done             <= 1'b0;
      range_x_low      <= '0;
      range_x_high     <= RESET_XHI;
      range_y_low      <= '0;
      range_y_high     <= RESET_YHI;
      ratio_horizontal <= RESET_RATH;
      ratio_vertical   <= RESET_RATV;
      event_mask       <= '0;
      notify_enable    <= 1'b0;
      pos_x            <= RESET_POSX;
      pos_y            <= RESET_POSY;
      mickey_x         <= '0;
      mickey_y         <= '0;
      fraction_x       <= '0;
      fraction_y       <= '0;
      last_buttons     <= '0;
      moved_flag       <= 1'b0;
      for (int i = 0; i < BUTTONS; i++) begin
        press_count[i]   <= '0;
        press_pos_x[i]   <= '0;
        press_pos_y[i]   <= '0;
        release_count[i] <= '0;
        release_pos_x[i] <= '0;
        release_pos_y[i] <= '0;
      end
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_XLO, REG_XHI, REG_YLO, REG_YHI: begin
            range_x_low  <= xlo_next;
            range_x_high <= xhi_next;
            range_y_low  <= ylo_next;
            range_y_high <= yhi_next;
            pos_x        <= clamp(18'(pos_x), xlo_next, xhi_next);
            pos_y        <= clamp(18'(pos_y), ylo_next, yhi_next);
          end
          REG_RATH: if (cfg_data[RatioBits-1:0] != '0)
            ratio_horizontal <= cfg_data[RatioBits-1:0];
          REG_RATV: if (cfg_data[RatioBits-1:0] != '0)
            ratio_vertical <= cfg_data[RatioBits-1:0];
          REG_EMASK: event_mask <= cfg_data[6:0];
          REG_NOTEN: notify_enable <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            event_bits <= '0;
            notify     <= 1'b0;
            info_count <= '0;
            info_x     <= '0;
            info_y     <= '0;
            buttons_now <= 3'(last_buttons);
            position_x <= pos_x;
            position_y <= pos_y;
            mickeys_x  <= mickey_x;
            mickeys_y  <= mickey_y;
            case (action)
              ACT_PACKET: begin
                nb_hold    <= nb;
                moved_flag <= moving;
                if (moving) begin
                  mickey_x <= mickey_x + 16'(dx);
                  mickey_y <= mickey_y + 16'(dy);
                  neg_x    <= sum_x[16];
                  neg_y    <= sum_y[16];
                  mag_y    <= abs_y[DivBits-1:0];
                  state    <= S_DIVX;
                end else begin
                  state <= S_FIN;
                end
              end
              ACT_PRESS: begin
                info_count       <= press_count[sel];
                info_x           <= press_pos_x[sel];
                info_y           <= press_pos_y[sel];
                press_count[sel] <= '0;
                done             <= 1'b1;
              end
              ACT_RELEASE: begin
                info_count         <= release_count[sel];
                info_x             <= release_pos_x[sel];
                info_y             <= release_pos_y[sel];
                release_count[sel] <= '0;
                done               <= 1'b1;
              end
              ACT_MOTION: begin
                mickey_x <= '0;
                mickey_y <= '0;
                done     <= 1'b1;
              end
              ACT_SETPOS: begin
                pos_x      <= clamp(18'(new_x), range_x_low, range_x_high);
                pos_y      <= clamp(18'(new_y), range_y_low, range_y_high);
                position_x <= clamp(18'(new_x), range_x_low, range_x_high);
                position_y <= clamp(18'(new_y), range_y_low, range_y_high);
                done       <= 1'b1;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_DIVX: begin
          if (dres.done) begin
            pos_x      <= axis_new;
            fraction_x <= frac_new;
            state      <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (dres.done) begin
            pos_y      <= axis_new;
            fraction_y <= frac_new;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          for (int i = 0; i < BUTTONS; i++) begin
            if (diff[i]) begin
              if (nb_hold[i]) begin
                press_count[i] <= press_count[i] + 16'd1;
                press_pos_x[i] <= pos_x;
                press_pos_y[i] <= pos_y;
              end else begin
                release_count[i] <= release_count[i] + 16'd1;
                release_pos_x[i] <= pos_x;
                release_pos_y[i] <= pos_y;
              end
            end
          end
          last_buttons <= nb_hold;
          buttons_now  <= 3'(nb_hold);
          position_x   <= pos_x;
          position_y   <= pos_y;
          mickeys_x    <= mickey_x;
          mickeys_y    <= mickey_y;
          event_bits   <= ev | {6'd0, moved_flag};
          notify       <= notify_enable && (((ev | {6'd0, moved_flag}) & event_mask) != 7'd0);
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic signed [15:0] xmin, xmax;
  assign xmin = (range_x_low < range_x_high) ? range_x_low : range_x_high;
  assign xmax = (range_x_low < range_x_high) ? range_x_high : range_x_low;

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (pos_x >= xmin) && (pos_x <= xmax))
    else $error("cursor left its horizontal range");

  a_div_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    dres.done |-> (state == S_DIVX || state == S_DIVY))
    else $error("divider finished outside a division state");

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy && action != ACT_PACKET) || $past(state) == S_FIN))
    else $error("result strobe without a finished action");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the mouse cursor tracker, with its own behavioural predictor.
`timescale 1ns / 1ps
module tb_top;
  import mtt_pkg::*;

  typedef struct packed {
    logic [2:0]         btn;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [6:0]         ev;
    logic               nt;
    logic [15:0]        cnt;
    logic signed [15:0] ix;
    logic signed [15:0] iy;
    logic signed [15:0] mx;
    logic signed [15:0] my;
  } tracker_res_t;

  typedef struct {
    logic [2:0]  act;
    logic [7:0]  st, dx, dy;
    logic [1:0]  sel;
    logic [15:0] nx, ny;
    logic        known;
    tracker_res_t res;
  } stim_row_t;

  logic clk = 0, rst = 1, start = 0, cfg_we = 0;
  logic busy, done;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic [2:0] action = '0;
  logic [7:0] packet_status = '0, motion_dx = '0, motion_dy = '0;
  logic [1:0] button_select = '0;
  logic signed [15:0] new_x = '0, new_y = '0;
  logic [2:0] buttons_now;
  logic signed [15:0] position_x, position_y, info_x, info_y, mickeys_x, mickeys_y;
  logic [6:0] event_bits;
  logic notify;
  logic [15:0] info_count;

  ps2_mouse_cursor_tracker uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state
  int xlo, xhi, ylo, yhi, rat_h, rat_v;
  logic [6:0] emask;
  logic nen;
  int cur_x, cur_y, frac_x, frac_y;
  logic [15:0] mick_x, mick_y;
  logic [2:0] prev_btn;
  logic [15:0] prs_cnt[3], rel_cnt[3];
  int prs_x[3], prs_y[3], rel_x[3], rel_y[3];

  tracker_res_t expected_q[$];
  int errors = 0;
  int sender_idle = 0;

  function automatic int clip(int v, int a, int b);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int s16(logic [15:0] v);
    return int'(signed'(v));
  endfunction

  task automatic reset_tracker();
    xlo = 0; xhi = 639; ylo = 0; yhi = 199; rat_h = 8; rat_v = 16;
    emask = '0; nen = 0; cur_x = 320; cur_y = 100; frac_x = 0; frac_y = 0;
    mick_x = '0; mick_y = '0; prev_btn = '0;
    for (int i = 0; i < 3; i++) begin
      prs_cnt[i] = 0; rel_cnt[i] = 0;
      prs_x[i] = 0; prs_y[i] = 0; rel_x[i] = 0; rel_y[i] = 0;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_XLO: xlo = s16(val);
      REG_XHI: xhi = s16(val);
      REG_YLO: ylo = s16(val);
      REG_YHI: yhi = s16(val);
      REG_RATH: if (val[14:0] != 0) rat_h = int'(val[14:0]);
      REG_RATV: if (val[14:0] != 0) rat_v = int'(val[14:0]);
      REG_EMASK: emask = val[6:0];
      REG_NOTEN: nen = val[0];
      default: ;
    endcase
    if (idx <= REG_YHI) begin
      cur_x = clip(cur_x, xlo, xhi);
      cur_y = clip(cur_y, ylo, yhi);
    end
  endtask

  function automatic int move_axis(inout int frac, input int ratio, input int d,
                                   input int pos, input int a, input int b);
    int sum, step;
    sum = frac + d * 8;
    step = sum / ratio;
    frac = sum - step * ratio;
    return clip(pos + step, a, b);
  endfunction

  function automatic tracker_res_t track_action(stim_row_t s);
    tracker_res_t r;
    int dx, dy, sel;
    logic [2:0] nb, diff;
    r = '{default: '0};
    sel = (s.sel > 2) ? 2 : int'(s.sel);
    case (s.act)
      ACT_PACKET: begin
        dx = s.dx; dy = s.dy;
        if (s.st[4]) dx -= 256;
        if (s.st[5]) dy -= 256;
        dy = -dy;
        nb = s.st[2:0];
        if (dx != 0 || dy != 0) begin
          r.ev[0] = 1;
          mick_x += 16'(dx); mick_y += 16'(dy);
          cur_x = move_axis(frac_x, rat_h, dx, cur_x, xlo, xhi);
          cur_y = move_axis(frac_y, rat_v, dy, cur_y, ylo, yhi);
        end
        diff = nb ^ prev_btn;
        for (int i = 0; i < 3; i++) begin
          if (diff[i]) begin
            if (nb[i]) begin
              prs_cnt[i]++; prs_x[i] = cur_x; prs_y[i] = cur_y; r.ev[2*i+1] = 1;
            end else begin
              rel_cnt[i]++; rel_x[i] = cur_x; rel_y[i] = cur_y; r.ev[2*i+2] = 1;
            end
          end
        end
        prev_btn = nb;
        r.nt = nen && ((r.ev & emask) != 0);
      end
      ACT_PRESS: begin
        r.cnt = prs_cnt[sel]; r.ix = 16'(prs_x[sel]); r.iy = 16'(prs_y[sel]);
        prs_cnt[sel] = 0;
      end
      ACT_RELEASE: begin
        r.cnt = rel_cnt[sel]; r.ix = 16'(rel_x[sel]); r.iy = 16'(rel_y[sel]);
        rel_cnt[sel] = 0;
      end
      ACT_SETPOS: begin
        cur_x = clip(s16(s.nx), xlo, xhi);
        cur_y = clip(s16(s.ny), ylo, yhi);
      end
      default: ;
    endcase
    r.mx = mick_x; r.my = mick_y;
    if (s.act == ACT_MOTION) begin
      mick_x = 0; mick_y = 0;
    end
    r.btn = prev_btn; r.px = 16'(cur_x); r.py = 16'(cur_y);
    return r;
  endfunction

  // Start stays high after a transfer only until the next item is driven or the
  // sender idles, so it is never assigned twice in one time step.
  task automatic issue(stim_row_t s);
    tracker_res_t r;
    while ($urandom_range(99) < sender_idle) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; action <= s.act; packet_status <= s.st; motion_dx <= s.dx;
    motion_dy <= s.dy; button_select <= s.sel; new_x <= s.nx; new_y <= s.ny;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = track_action(s);
    if (s.known && r != s.res) begin
      errors++;
      if (errors <= 10) $display("predictor disagrees with typed row, act %0d", s.act);
    end
    expected_q.push_back(r);
  endtask

  // Result checker
  always @(posedge clk) begin
    tracker_res_t e, a;
    if (!rst && done) begin
      a = '{buttons_now, position_x, position_y, event_bits, notify, info_count,
            info_x, info_y, mickeys_x, mickeys_y};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result at %0t", $time);
      end else begin
        e = expected_q.pop_front();
        if (a != e) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp btn=%h x=%0d y=%0d ev=%h n=%b c=%0d ix=%0d iy=%0d mx=%0d my=%0d",
                     e.btn, e.px, e.py, e.ev, e.nt, e.cnt, e.ix, e.iy, e.mx, e.my,
                     "\n          got btn=%h x=%0d y=%0d ev=%h n=%b c=%0d ix=%0d iy=%0d mx=%0d my=%0d",
                     a.btn, a.px, a.py, a.ev, a.nt, a.cnt, a.ix, a.iy, a.mx, a.my);
        end
      end
    end
  end

  function automatic stim_row_t mk(logic [2:0] act, logic [7:0] st, logic [7:0] dx,
                                   logic [7:0] dy, logic [1:0] sel, logic [15:0] nx,
                                   logic [15:0] ny);
    stim_row_t s;
    s = '{act, st, dx, dy, sel, nx, ny, 1'b0, '{default: '0}};
    return s;
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t s;
    int k;
    k = $urandom_range(99);
    s = mk(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
           16'($urandom), 16'($urandom));
    if (k < 55) begin
      s.act = ACT_PACKET;
      if (k < 35) begin
        s.dx = 8'($urandom_range(6)); s.dy = 8'($urandom_range(6));
        s.st[4] = $urandom_range(1) ? 1'b1 : 1'b0;
        if (s.st[4]) s.dx = -s.dx;
        if (s.st[5]) s.dy = -s.dy;
      end else if (k < 40) begin
        s.dx = 0; s.dy = 0; s.st[5:4] = 0;
      end
    end else if (k < 70) s.act = ACT_PRESS;
    else if (k < 85) s.act = ACT_RELEASE;
    else if (k < 92) s.act = ACT_MOTION;
    else if (k < 98) begin
      s.act = ACT_SETPOS;
      if (k < 96) begin
        s.nx = 16'($urandom_range(700) - 30); s.ny = 16'($urandom_range(260) - 30);
      end
    end else s.act = 3'(5 + $urandom_range(2));
    return s;
  endfunction

  task automatic drain();
    start <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  stim_row_t table_rows[$];
  stim_row_t row;

  initial begin
    reset_tracker();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed rows; the first two are typed in from the reset state.
    row = mk(ACT_MOTION, 0, 0, 0, 0, 0, 0); row.known = 1;
    row.res = '{0, 320, 100, 0, 0, 0, 0, 0, 0, 0};
    table_rows.push_back(row);
    row = mk(ACT_PRESS, 0, 0, 0, 2'd3, 0, 0); row.known = 1;
    row.res = '{0, 320, 100, 0, 0, 0, 0, 0, 0, 0};
    table_rows.push_back(row);
    table_rows.push_back(mk(ACT_PACKET, 8'h07, 8'h7f, 8'h7f, 0, 0, 0));
    table_rows.push_back(mk(ACT_PACKET, 8'h30, 8'h80, 8'h80, 0, 0, 0));
    table_rows.push_back(mk(ACT_PACKET, 8'hc8, 8'h00, 8'h00, 0, 0, 0));
    table_rows.push_back(mk(ACT_PACKET, 8'h30, 8'h00, 8'h00, 0, 0, 0));
    table_rows.push_back(mk(ACT_PACKET, 8'h3f, 8'hff, 8'hff, 0, 0, 0));
    table_rows.push_back(mk(ACT_PACKET, 8'h00, 8'hff, 8'hff, 0, 0, 0));
    for (int b = 0; b < 4; b++) begin
      table_rows.push_back(mk(ACT_PRESS, 0, 0, 0, 2'(b), 0, 0));
      table_rows.push_back(mk(ACT_RELEASE, 0, 0, 0, 2'(b), 0, 0));
    end
    table_rows.push_back(mk(ACT_MOTION, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(ACT_SETPOS, 0, 0, 0, 0, 16'h8000, 16'h7fff));
    table_rows.push_back(mk(ACT_SETPOS, 0, 0, 0, 0, 16'h7fff, 16'h8000));
    table_rows.push_back(mk(3'd5, 8'hff, 1, 1, 3, 1, 1));
    table_rows.push_back(mk(3'd7, 8'h01, 1, 1, 3, 1, 1));

    write_reg(REG_EMASK, 16'h007f);
    write_reg(REG_NOTEN, 16'h0001);
    foreach (table_rows[i]) issue(table_rows[i]);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_XLO, 16'h7fff); write_reg(REG_XHI, 16'h8000);
          write_reg(REG_YLO, 16'h8000); write_reg(REG_YHI, 16'h7fff);
          write_reg(REG_RATH, 16'h0001); write_reg(REG_RATV, 16'h7fff);
        end
        2: begin
          write_reg(REG_XLO, 16'd100); write_reg(REG_XHI, 16'hffd0);
          write_reg(REG_YLO, 16'd50); write_reg(REG_YHI, 16'd40);
          write_reg(REG_RATH, 16'h0000); write_reg(REG_RATV, 16'h8003);
          write_reg(REG_EMASK, 16'h002a); write_reg(REG_NOTEN, 16'h0000);
        end
        3: begin
          write_reg(REG_XLO, 16'd0); write_reg(REG_XHI, 16'd639);
          write_reg(REG_YLO, 16'd0); write_reg(REG_YHI, 16'd199);
          write_reg(REG_RATH, 16'd5); write_reg(REG_RATV, 16'd7);
          write_reg(REG_EMASK, 16'h0054); write_reg(REG_NOTEN, 16'hfffe);
        end
        4: begin
          write_reg(REG_RATH, 16'd3); write_reg(REG_RATV, 16'd1);
          write_reg(REG_EMASK, 16'h0001); write_reg(REG_NOTEN, 16'h0001);
        end
        5: begin
          write_reg(REG_RATH, 16'd8); write_reg(REG_RATV, 16'd16);
        end
        default: ;
      endcase
      sender_idle = (ph < 2) ? 15 : ((ph < 4) ? 87 : 0);
      for (int n = 0; n < 267; n++) begin
        if (n == 130) begin
          start <= 0;
          while (expected_q.size() != 0) @(posedge clk);
        end
        issue(rand_row());
      end
      drain();
    end

    if (errors == 0 && expected_q.size() == 0) begin
      $display("** ps2_mouse_cursor_tracker: PASSED **");
    end else begin
      $display("** ps2_mouse_cursor_tracker: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** ps2_mouse_cursor_tracker: FAILED **");
    $finish;
  end
endmodule
